>>> hw/rtl/perspective_point_projector_unit_macros.svh
// ----------------------------------------------------------------------------
// Perspective point projector assertion macros
// Shared concurrent check forms, clocked on clk and idle during rst.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_POINT_PROJECTOR_UNIT_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define PPP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppp check failed");

// next-cycle implication
`define PPP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppp check failed");

`endif

>>> hw/rtl/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perspective point projector package
// Shared widths, codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int CLIP_W = 48;
  localparam int NUM_W  = 63;
  localparam int DEN_W  = 47;
  localparam int QUO_W  = 17;

  typedef logic signed [CLIP_W-1:0] clip_t;

  typedef struct packed {
    logic valid;
    logic visible;
    logic neg;
  } div_tag_t;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  typedef enum logic [1:0] {
    REG_VIEWPORT_WIDTH  = 2'd0,
    REG_VIEWPORT_HEIGHT = 2'd1,
    REG_VERTICAL_OFFSET = 2'd2,
    REG_MIN_CLIP_W      = 2'd3
  } cfg_reg_t;

  localparam logic [13:0] RESET_VIEWPORT_WIDTH  = 14'd1920;
  localparam logic [13:0] RESET_VIEWPORT_HEIGHT = 14'd1080;
  localparam logic [7:0]  RESET_VERTICAL_OFFSET = 8'd30;
  localparam logic [16:0] RESET_MIN_CLIP_W      = 17'd655;

endpackage

>>> hw/rtl/perspective_point_projector_unit.sv
// An input transfer passes the clip stages, the map stages, the 17-stage divider pipeline and the output register.
// Throughput: one item per cycle while the output is not stalled.
// Load items write the coefficient store at transfer and give no result.
// A stalled output freezes every stage; nothing is dropped or repeated.
// Reset (synchronous, rst high) clears all valid bits and the store, and
// restores the register defaults.
`timescale 1ns / 1ps
`include "perspective_point_projector_unit_macros.svh"
// ----------------------------------------------------------------------------
// Perspective point projector
// Matrix transform, viewport mapping and pipelined divide to pixel coordinates.
// ----------------------------------------------------------------------------
module perspective_point_projector_unit
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               visible,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic               saturated
);

  logic [13:0] viewport_width;
  logic [13:0] viewport_height;
  logic [7:0]  vertical_offset;
  logic [16:0] min_clip_w;

  logic             advance;
  logic             in_xfer;
  logic             clip_valid;
  clip_t            cx, cy, cw;
  div_tag_t         tag_x, tag_y, tag_xo, tag_yo;
  logic [NUM_W-1:0] mag_x, mag_y;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] quo_x, quo_y;

  logic signed [15:0] px_next, py_next;
  logic               sx_next, sy_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_width  <= RESET_VIEWPORT_WIDTH;
      viewport_height <= RESET_VIEWPORT_HEIGHT;
      vertical_offset <= RESET_VERTICAL_OFFSET;
      min_clip_w      <= RESET_MIN_CLIP_W;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEWPORT_WIDTH:  viewport_width  <= cfg_data[13:0];
        REG_VIEWPORT_HEIGHT: viewport_height <= cfg_data[13:0];
        REG_VERTICAL_OFFSET: vertical_offset <= cfg_data[7:0];
        REG_MIN_CLIP_W:      min_clip_w      <= cfg_data;
        default: ;
      endcase
    end
  end

  ppp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .load_en    (in_xfer && operation == OP_LOAD),
    .load_index (coef_index),
    .load_value (coef_value),
    .in_valid   (in_xfer && operation == OP_PROJECT),
    .px         (point_x),
    .py         (point_y),
    .pz         (point_z),
    .out_valid  (clip_valid),
    .cx         (cx),
    .cy         (cy),
    .cw         (cw)
  );

  ppp_map u_map (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (clip_valid),
    .cx       (cx),
    .cy       (cy),
    .cw       (cw),
    .half_w   (viewport_width[13:1]),
    .half_h   (viewport_height[13:1]),
    .offset   (vertical_offset),
    .min_w    (min_clip_w),
    .tag_x    (tag_x),
    .tag_y    (tag_y),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .den      (den)
  );

  ppp_div u_div_x (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (tag_x),
    .num     (mag_x),
    .den     (den),
    .tag_out (tag_xo),
    .quo     (quo_x)
  );

  ppp_div u_div_y (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (tag_y),
    .num     (mag_y),
    .den     (den),
    .tag_out (tag_yo),
    .quo     (quo_y)
  );

  always_comb begin
    if (!tag_xo.neg) begin
      sx_next = quo_x > QUO_W'(32767);
      px_next = sx_next ? 16'sh7FFF : $signed(quo_x[15:0]);
    end else begin
      sx_next = quo_x > QUO_W'(32768);
      px_next = sx_next ? 16'sh8000 : $signed(16'(QUO_W'(0) - quo_x));
    end
    if (!tag_yo.neg) begin
      sy_next = quo_y > QUO_W'(32767);
      py_next = sy_next ? 16'sh7FFF : $signed(quo_y[15:0]);
    end else begin
      sy_next = quo_y > QUO_W'(32768);
      py_next = sy_next ? 16'sh8000 : $signed(16'(QUO_W'(0) - quo_y));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tag_xo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      visible   <= tag_xo.visible;
      pixel_x   <= tag_xo.visible ? px_next : 16'sd0;
      pixel_y   <= tag_xo.visible ? py_next : 16'sd0;
      saturated <= tag_xo.visible && (sx_next || sy_next);
    end
  end

  `PPP_ASSERT_IMP(a_hidden_zero, out_valid && !visible, pixel_x == 16'sd0 && pixel_y == 16'sd0 && !saturated)
  `PPP_ASSERT_IMP(a_sat_clamped, out_valid && saturated, pixel_x == 16'sh7FFF || pixel_x == 16'sh8000 || pixel_y == 16'sh7FFF || pixel_y == 16'sh8000)
  `PPP_ASSERT_IMP(a_lanes_aligned, tag_xo.valid || tag_yo.valid, tag_xo.valid == tag_yo.valid && tag_xo.visible == tag_yo.visible)
  `PPP_ASSERT_NXT(a_drain, out_valid && out_ready && !tag_xo.valid, !out_valid)

endmodule

>>> hw/rtl/ppp_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip coordinate pipeline
// Coefficient store, row products and clamped clip sums over three stages.
// ----------------------------------------------------------------------------
module ppp_clip
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               load_en,
  input  logic [3:0]         load_index,
  input  logic [31:0]        load_value,
  input  logic               in_valid,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic               out_valid,
  output clip_t              cx,
  output clip_t              cy,
  output clip_t              cw
);

  localparam logic signed [65:0] SUM_MAX = (66'sd1 <<< (CLIP_W - 1)) - 66'sd1;
  localparam logic signed [65:0] SUM_MIN = -(66'sd1 <<< (CLIP_W - 1));

  logic [31:0] store [16];

  logic               a_valid;
  logic signed [31:0] a_pt   [3];
  logic signed [31:0] a_coef [12];

  logic               b_valid;
  logic signed [63:0] b_prod  [9];
  logic signed [31:0] b_trans [3];

  logic               c_valid;
  clip_t              c_clip [3];
  clip_t              clip_next [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) store[i] <= '0;
    end else if (load_en) begin
      store[load_index] <= load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_pt[0] <= px;
      a_pt[1] <= py;
      a_pt[2] <= pz;
      for (int c = 0; c < 4; c++) begin
        a_coef[c]     <= $signed(store[c]);
        a_coef[4 + c] <= $signed(store[4 + c]);
        a_coef[8 + c] <= $signed(store[12 + c]);
      end
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          b_prod[k*3 + c] <= 64'(a_coef[k*4 + c]) * 64'(a_pt[c]);
        end
        b_trans[k] <= a_coef[k*4 + 3];
        c_clip[k]  <= clip_next[k];
      end
    end
  end

  always_comb begin
    logic signed [65:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = 66'(b_trans[k]);
      for (int c = 0; c < 3; c++) begin
        sum = sum + (66'(b_prod[k*3 + c]) >>> FRAC_BITS);
      end
      if (sum > SUM_MAX) begin
        clip_next[k] = clip_t'(SUM_MAX);
      end else if (sum < SUM_MIN) begin
        clip_next[k] = clip_t'(SUM_MIN);
      end else begin
        clip_next[k] = clip_t'(sum);
      end
    end
  end

  assign out_valid = c_valid;
  assign cx        = c_clip[0];
  assign cy        = c_clip[1];
  assign cw        = c_clip[2];

endmodule

>>> hw/rtl/ppp_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viewport mapping pipeline
// Visibility test, scaled numerators, sign and magnitude over three stages.
// ----------------------------------------------------------------------------
module ppp_map
  import ppp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  clip_t            cx,
  input  clip_t            cy,
  input  clip_t            cw,
  input  logic [12:0]      half_w,
  input  logic [12:0]      half_h,
  input  logic [7:0]       offset,
  input  logic [16:0]      min_w,
  output div_tag_t         tag_x,
  output div_tag_t         tag_y,
  output logic [NUM_W-1:0] mag_x,
  output logic [NUM_W-1:0] mag_y,
  output logic [DEN_W-1:0] den
);

  logic               d_valid;
  logic               d_vis;
  logic signed [63:0] d_nx;
  logic signed [63:0] d_ny_a;
  logic signed [63:0] d_ny_b;
  clip_t              d_cw;

  logic               e_valid;
  logic               e_vis;
  logic signed [63:0] e_nx;
  logic signed [63:0] e_ny;
  clip_t              e_cw;

  logic               f_valid;
  logic               f_vis;
  logic               f_negx;
  logic               f_negy;
  logic [NUM_W-1:0]   f_magx;
  logic [NUM_W-1:0]   f_magy;
  logic [DEN_W-1:0]   f_den;

  logic               vis_next;
  logic signed [48:0] sum_x;
  logic signed [48:0] dif_y;

  assign vis_next = (cw > clip_t'(0)) && (cw >= $signed({31'd0, min_w}));
  assign sum_x    = 49'(cw) + 49'(cx);
  assign dif_y    = 49'(cw) - 49'(cy);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (advance) begin
      d_valid <= in_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d_vis  <= vis_next;
      d_nx   <= 64'($signed({1'b0, half_w})) * 64'(sum_x);
      d_ny_a <= 64'($signed({1'b0, half_h})) * 64'(dif_y);
      d_ny_b <= 64'($signed({1'b0, offset})) * 64'(cw);
      d_cw   <= cw;

      e_vis <= d_vis;
      e_nx  <= d_nx;
      e_ny  <= d_ny_a + d_ny_b;
      e_cw  <= d_cw;

      f_vis  <= e_vis;
      f_negx <= e_nx[63];
      f_negy <= e_ny[63];
      f_magx <= e_nx[63] ? NUM_W'(-e_nx) : e_nx[NUM_W-1:0];
      f_magy <= e_ny[63] ? NUM_W'(-e_ny) : e_ny[NUM_W-1:0];
      f_den  <= e_cw[DEN_W-1:0];
    end
  end

  assign tag_x = '{valid: f_valid, visible: f_vis, neg: f_negx};
  assign tag_y = '{valid: f_valid, visible: f_vis, neg: f_negy};
  assign mag_x = f_magx;
  assign mag_y = f_magy;
  assign den   = f_den;

endmodule

>>> hw/rtl/ppp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, overflow bit first, tag carried alongside.
// ----------------------------------------------------------------------------
module ppp_div
  import ppp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  div_tag_t         tag_in,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_tag_t         tag_out,
  output logic [QUO_W-1:0] quo
);

  div_tag_t         tag      [QUO_W];
  logic [NUM_W-1:0] rem      [QUO_W];
  logic [DEN_W-1:0] dv       [QUO_W];
  logic [QUO_W-1:0] q        [QUO_W];

  div_tag_t         tag_src  [QUO_W];
  logic [NUM_W-1:0] rem_src  [QUO_W];
  logic [DEN_W-1:0] dv_src   [QUO_W];
  logic [QUO_W-1:0] q_src    [QUO_W];
  logic [NUM_W-1:0] rem_next [QUO_W];
  logic [QUO_W-1:0] q_next   [QUO_W];

  always_comb begin
    logic [63:0] trial;
    tag_src[0] = tag_in;
    rem_src[0] = num;
    dv_src[0]  = den;
    q_src[0]   = '0;
    for (int s = 1; s < QUO_W; s++) begin
      tag_src[s] = tag[s-1];
      rem_src[s] = rem[s-1];
      dv_src[s]  = dv[s-1];
      q_src[s]   = q[s-1];
    end
    for (int s = 0; s < QUO_W; s++) begin
      trial = 64'(dv_src[s]) << (QUO_W - 1 - s);
      if (64'(rem_src[s]) >= trial) begin
        rem_next[s] = NUM_W'(64'(rem_src[s]) - trial);
        q_next[s]   = q_src[s] | (QUO_W'(1) << (QUO_W - 1 - s));
      end else begin
        rem_next[s] = rem_src[s];
        q_next[s]   = q_src[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QUO_W; s++) begin
      if (rst) begin
        tag[s].valid <= 1'b0;
      end else if (advance) begin
        tag[s].valid <= tag_src[s].valid;
      end
      if (advance) begin
        tag[s].visible <= tag_src[s].visible;
        tag[s].neg     <= tag_src[s].neg;
        dv[s]          <= dv_src[s];
        rem[s]         <= rem_next[s];
        q[s]           <= q_next[s];
      end
    end
  end

  assign tag_out = tag[QUO_W-1];
  assign quo     = q[QUO_W-1];

endmodule
